/* rtl/core/kdcs_pkg.sv */
// Shared types and constants for the knob delta to cursor steps unit.
// Standalone package; used by the controller, datapath and top level.
`default_nettype none

package kdcs_pkg;

    localparam int ACC_W     = 21;
    localparam int DELTA_W   = 16;
    localparam int FTIME_W   = 16;
    localparam int THR_W     = 16;
    localparam int IDLE_W    = 24;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int DIV_CNT_W = $clog2(ACC_W);

    localparam logic [COUNT_W-1:0] FAST_AFTER = 8'd10;
    localparam logic [COUNT_W-1:0] MULTI_FROM = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_FIRST  = 3'd0,
        CFG_THR_SECOND = 3'd1,
        CFG_THR_NORMAL = 3'd2,
        CFG_THR_FAST   = 3'd3,
        CFG_DETECT     = 3'd4,
        CFG_IDLE_LIMIT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]  thr_first;
        logic [THR_W-1:0]  thr_second;
        logic [THR_W-1:0]  thr_normal;
        logic [THR_W-1:0]  thr_fast;
        logic [THR_W-1:0]  detect_level;
        logic [IDLE_W-1:0] idle_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_PICK,
        S_DECIDE,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic update;
        logic pick;
        logic decide;
        logic div_step;
        logic div_fin;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic reach;
        logic multi;
        logic div_last;
    } t_status;

endpackage

`default_nettype wire

/* rtl/core/kdcs_ctrl.sv */
// Sequencing state machine for the knob delta to cursor steps unit.
// Depends on kdcs_pkg for the state, command and status types.
`default_nettype none

module kdcs_ctrl import kdcs_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_UPDATE;
            S_UPDATE: n_state = S_PICK;
            S_PICK:   n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_status.reach && i_status.multi) n_state = S_DIV;
                else n_state = S_EMIT;
            end
            S_DIV:    if (i_status.div_last) n_state = S_FIN;
            S_FIN:    n_state = S_EMIT;
            S_EMIT:   if (slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_UPDATE: o_cmd.update   = 1'b1;
            S_PICK:   o_cmd.pick     = 1'b1;
            S_DECIDE: o_cmd.decide   = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_FIN:    o_cmd.div_fin  = 1'b1;
            S_EMIT:   o_cmd.emit     = slot_free;
            default:  o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/core/kdcs_dp.sv */
// Datapath: accumulator, move count, idle timer and restoring divider.
// Depends on kdcs_pkg; driven by commands from kdcs_ctrl.
`default_nettype none

module kdcs_dp import kdcs_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cfg                       i_cfg,
    input  wire t_cmd                       i_cmd,
    input  wire logic signed [DELTA_W-1:0]  i_knob_delta,
    input  wire logic [FTIME_W-1:0]         i_frame_time_us,
    output t_status                         o_status,
    output logic signed [ACC_W-1:0]         o_cursor_steps
);

    logic signed [DELTA_W-1:0] r_delta;
    logic [FTIME_W-1:0]        r_ftime;
    logic [ACC_W-1:0]          r_acc, n_acc;
    logic [COUNT_W-1:0]        r_count, n_count;
    logic [IDLE_W-1:0]         r_idle, n_idle;
    logic [THR_W-1:0]          r_thr;
    logic [ACC_W-1:0]          r_mag;
    logic                      r_neg;
    logic [THR_W-1:0]          r_rem;
    logic [ACC_W-1:0]          r_quo;
    logic [DIV_CNT_W-1:0]      r_div_cnt;
    logic [ACC_W-1:0]          r_steps, n_steps;
    logic [ACC_W-1:0]          r_out;

    // update stage
    logic [ACC_W:0]     sum_ext;
    logic [ACC_W-1:0]   sum_sat;
    logic [DELTA_W:0]   mag_delta;
    logic [IDLE_W:0]    idle_sum;
    logic [IDLE_W-1:0]  idle_sat;
    // pick stage
    logic [THR_W-1:0]   thr_sel;
    // divider
    logic [THR_W:0]     rem_sh;
    logic               sub_ok;
    // finish
    logic [COUNT_W:0]   cnt_sum;
    logic [COUNT_W-1:0] cnt_sat_q;
    logic [COUNT_W-1:0] cnt_inc;

    always_comb begin
        sum_ext = {r_acc[ACC_W-1], r_acc} +
                  {{(ACC_W+1-DELTA_W){r_delta[DELTA_W-1]}}, r_delta};
        if (sum_ext[ACC_W] != sum_ext[ACC_W-1])
            sum_sat = sum_ext[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        else
            sum_sat = sum_ext[ACC_W-1:0];

        mag_delta = r_delta[DELTA_W-1] ? (DELTA_W+1)'(-{r_delta[DELTA_W-1], r_delta})
                                       : {1'b0, r_delta};
        idle_sum  = {1'b0, r_idle} + {{(IDLE_W+1-FTIME_W){1'b0}}, r_ftime};
        idle_sat  = idle_sum[IDLE_W] ? {IDLE_W{1'b1}} : idle_sum[IDLE_W-1:0];

        if (r_count == '0)            thr_sel = i_cfg.thr_first;
        else if (r_count == 8'd1)     thr_sel = i_cfg.thr_second;
        else if (r_count > FAST_AFTER) thr_sel = i_cfg.thr_fast;
        else                          thr_sel = i_cfg.thr_normal;

        rem_sh = {r_rem, r_quo[ACC_W-1]};
        sub_ok = rem_sh >= {1'b0, r_thr};

        cnt_sum   = {1'b0, r_count} + {1'b0, r_quo[COUNT_W-1:0]};
        cnt_sat_q = (r_quo[ACC_W-1:COUNT_W] != '0 || cnt_sum[COUNT_W])
                    ? {COUNT_W{1'b1}} : cnt_sum[COUNT_W-1:0];
        cnt_inc   = (r_count == {COUNT_W{1'b1}}) ? r_count : r_count + 1'b1;
    end

    assign o_status.reach    = r_mag >= {{(ACC_W-THR_W){1'b0}}, r_thr};
    assign o_status.multi    = r_count >= MULTI_FROM;
    assign o_status.div_last = r_div_cnt == DIV_CNT_W'(ACC_W-1);

    always_comb begin
        n_acc   = r_acc;
        n_count = r_count;
        n_idle  = r_idle;
        n_steps = r_steps;
        if (i_cmd.update) begin
            n_acc = sum_sat;
            if (r_acc != '0 && sum_sat != '0 && r_acc[ACC_W-1] != sum_sat[ACC_W-1])
                n_count = '0;
            if (mag_delta > {1'b0, i_cfg.detect_level}) begin
                n_idle = '0;
            end else begin
                n_idle = idle_sat;
                if (idle_sat > i_cfg.idle_limit) begin
                    n_count = '0;
                    n_acc   = '0;
                end
            end
        end
        if (i_cmd.decide) begin
            n_steps = '0;
            if (o_status.reach && !o_status.multi) begin
                n_steps = r_neg ? {ACC_W{1'b1}} : ACC_W'(1);
                n_acc   = '0;
                n_count = cnt_inc;
            end
        end
        if (i_cmd.div_fin) begin
            n_steps = r_neg ? ACC_W'(-r_quo) : r_quo;
            n_acc   = r_neg ? ACC_W'(-{{(ACC_W-THR_W){1'b0}}, r_rem})
                            : {{(ACC_W-THR_W){1'b0}}, r_rem};
            n_count = cnt_sat_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
            r_idle  <= '0;
        end else begin
            r_acc   <= n_acc;
            r_count <= n_count;
            r_idle  <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_delta <= i_knob_delta;
            r_ftime <= i_frame_time_us;
        end
        if (i_cmd.pick) begin
            // a zero threshold register acts as one
            r_thr <= (thr_sel == '0) ? THR_W'(1) : thr_sel;
            r_mag <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : r_acc;
            r_neg <= r_acc[ACC_W-1];
        end
        if (i_cmd.decide) begin
            r_rem     <= '0;
            r_quo     <= r_mag;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            // restoring division, one quotient bit per cycle
            r_rem     <= sub_ok ? THR_W'(rem_sh - {1'b0, r_thr}) : rem_sh[THR_W-1:0];
            r_quo     <= {r_quo[ACC_W-2:0], sub_ok};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        r_steps <= n_steps;
        if (i_cmd.emit) r_out <= r_steps;
    end

    assign o_cursor_steps = r_out;

endmodule

`default_nettype wire

/* rtl/core/knob_delta_to_cursor_steps_unit.sv */
// The result is registered in the emit state, once the output slot is free. That state
// follows update, pick and decide, and on the multi-step path also the restoring divider
// and its finish state. A new input transaction is taken only in the idle state.
// A new input transaction is taken while the previous result still waits on the output.
// Reset (synchronous, active low) clears accumulator, move count, idle timer and
// loads the default thresholds, detection level and idle limit.
// Depends on kdcs_pkg, kdcs_ctrl and kdcs_dp.
`default_nettype none

module knob_delta_to_cursor_steps_unit import kdcs_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic signed [DELTA_W-1:0] i_knob_delta,
    input  wire logic [FTIME_W-1:0]        i_frame_time_us,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [ACC_W-1:0]        o_cursor_steps,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]      i_cfg_data
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_first    <= 16'd512;
            r_cfg.thr_second   <= 16'd717;
            r_cfg.thr_normal   <= 16'd410;
            r_cfg.thr_fast     <= 16'd205;
            r_cfg.detect_level <= 16'd1;
            r_cfg.idle_limit   <= 24'd300000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THR_FIRST:  r_cfg.thr_first    <= i_cfg_data[THR_W-1:0];
                CFG_THR_SECOND: r_cfg.thr_second   <= i_cfg_data[THR_W-1:0];
                CFG_THR_NORMAL: r_cfg.thr_normal   <= i_cfg_data[THR_W-1:0];
                CFG_THR_FAST:   r_cfg.thr_fast     <= i_cfg_data[THR_W-1:0];
                CFG_DETECT:     r_cfg.detect_level <= i_cfg_data[THR_W-1:0];
                CFG_IDLE_LIMIT: r_cfg.idle_limit   <= i_cfg_data[IDLE_W-1:0];
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    kdcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kdcs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .i_knob_delta    (i_knob_delta),
        .i_frame_time_us (i_frame_time_us),
        .o_status        (status),
        .o_cursor_steps  (o_cursor_steps)
    );

endmodule

`default_nettype wire

/* tb/knob_delta_to_cursor_steps_unit_tb.sv */
// Testbench for knob_delta_to_cursor_steps_unit: a directed table of frames, then random gestures
// under several register settings. Every output transaction is checked in order against a typed
// value or an in-line predictor. Depends on kdcs_pkg and the unit RTL.
`timescale 1ns / 100ps

module knob_delta_to_cursor_steps_unit_tb;
    import kdcs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_LEN     = 300;
    localparam int ACC_MAX      = (1 << (ACC_W - 1)) - 1;
    localparam int ACC_MIN      = -(1 << (ACC_W - 1));
    localparam int IDLE_MAX     = (1 << IDLE_W) - 1;
    localparam int COUNT_MAX    = (1 << COUNT_W) - 1;

    // unused register slots, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic [FTIME_W-1:0]        ft;
        logic                      check_fixed;
        logic signed [ACC_W-1:0]   typed_steps;
    } t_frame_row;

    localparam int N_ROWS = 21;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    wire                       o_in_ready;
    logic signed [DELTA_W-1:0] i_knob_delta = '0;
    logic [FTIME_W-1:0]        i_frame_time_us = '0;
    wire                       o_out_valid;
    logic                      i_out_ready = 1'b0;
    wire signed [ACC_W-1:0]    o_cursor_steps;
    logic                      i_cfg_valid = 1'b0;
    wire                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]      i_cfg_data = '0;

    // predictor state and register copy
    t_cfg                      model_cfg;
    logic signed [ACC_W-1:0]   model_acc;
    logic [COUNT_W-1:0]        model_count;
    logic [IDLE_W-1:0]         model_idle;

    logic signed [ACC_W-1:0]   expected_steps [$];
    logic signed [ACC_W-1:0]   oldest_steps;
    int                        mismatch_count = 0;
    int                        cycle_count = 0;
    int                        hold_cycles = 0;
    int                        gesture_dir = 1;
    bit                        in_idle_on = 1'b1;
    bit                        out_idle_on = 1'b1;

    t_frame_row directed_rows [0:N_ROWS-1] = '{
        '{16'sd0,      16'd0,     1'b1, 21'sd0},   // quiet frame right after reset
        '{16'sd511,    16'd100,   1'b1, 21'sd0},   // just below first threshold
        '{16'sd1,      16'd100,   1'b1, 21'sd1},   // reach first threshold, delta at detect level
        '{16'sd717,    16'd16000, 1'b1, 21'sd1},   // second threshold
        '{16'sh7FFF,   16'd16000, 1'b0, 21'sd0},   // largest delta, multi-step path
        '{16'sh8000,   16'd16000, 1'b1, -21'sd1},  // smallest delta, direction flip
        '{-16'sd717,   16'd16000, 1'b1, -21'sd1},
        '{-16'sd1230,  16'd16000, 1'b0, 21'sd0},
        '{-16'sd1,     16'hFFFF,  1'b0, 21'sd0},   // still frames until the idle limit passes
        '{16'sd0,      16'hFFFF,  1'b0, 21'sd0},
        '{16'sd0,      16'hFFFF,  1'b0, 21'sd0},
        '{16'sd0,      16'hFFFF,  1'b0, 21'sd0},
        '{16'sd0,      16'hFFFF,  1'b0, 21'sd0},
        '{16'sd2,      16'd16000, 1'b0, 21'sd0},
        '{16'sd512,    16'd16000, 1'b0, 21'sd0},
        '{16'sd717,    16'd16000, 1'b0, 21'sd0},
        '{16'sh7FFF,   16'd16000, 1'b0, 21'sd0},   // into the fast threshold
        '{16'sh7FFF,   16'd16000, 1'b0, 21'sd0},
        '{16'sh7FFF,   16'd16000, 1'b0, 21'sd0},   // move count saturates
        '{-16'sd1,     16'd0,     1'b0, 21'sd0},
        '{16'sd0,      16'd0,     1'b0, 21'sd0}
    };

    knob_delta_to_cursor_steps_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_knob_delta    (i_knob_delta),
        .i_frame_time_us (i_frame_time_us),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cursor_steps  (o_cursor_steps),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [ACC_W-1:0] predict_cursor_steps(
            input logic signed [DELTA_W-1:0] delta, input logic [FTIME_W-1:0] ft);
        int prev;
        int sum;
        int dmag;
        int thr;
        int mag;
        int q;
        int steps;
        int total;
        longint idle_sum;
        logic [THR_W-1:0] thr_raw;
        prev = model_acc;
        sum = prev + delta;
        if (sum > ACC_MAX) sum = ACC_MAX;
        if (sum < ACC_MIN) sum = ACC_MIN;
        model_acc = ACC_W'(sum);
        // clear the count when the accumulator changes sign between nonzero values
        if (prev != 0 && sum != 0 && ((prev < 0) != (sum < 0))) model_count = '0;
        dmag = (delta < 0) ? -int'(delta) : int'(delta);
        if (dmag > int'(model_cfg.detect_level)) begin
            model_idle = '0;
        end else begin
            idle_sum = longint'(model_idle) + longint'(ft);
            model_idle = (idle_sum > IDLE_MAX) ? IDLE_W'(IDLE_MAX) : idle_sum[IDLE_W-1:0];
            if (model_idle > model_cfg.idle_limit) begin
                model_count = '0;
                model_acc = '0;
            end
        end
        if (model_count == 0) thr_raw = model_cfg.thr_first;
        else if (model_count == 1) thr_raw = model_cfg.thr_second;
        else if (model_count > FAST_AFTER) thr_raw = model_cfg.thr_fast;
        else thr_raw = model_cfg.thr_normal;
        thr = (thr_raw == 0) ? 1 : int'(thr_raw);
        mag = (model_acc < 0) ? -int'(model_acc) : int'(model_acc);
        steps = 0;
        if (mag >= thr) begin
            if (model_count >= MULTI_FROM) begin
                q = mag / thr;
                if (model_acc < 0) begin
                    steps = -q;
                    model_acc = ACC_W'(q * thr - mag);
                end else begin
                    steps = q;
                    model_acc = ACC_W'(mag - q * thr);
                end
                total = int'(model_count) + q;
            end else begin
                steps = (model_acc < 0) ? -1 : 1;
                model_acc = '0;
                total = int'(model_count) + 1;
            end
            model_count = (total > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : total[COUNT_W-1:0];
        end
        return steps[ACC_W-1:0];
    endfunction

    // Mostly same-direction gestures, with reversals, still frames, extremes and noise.
    function automatic logic signed [DELTA_W-1:0] draw_delta(input int scale);
        int pick;
        int mag;
        pick = $urandom_range(0, 99);
        if (pick < 6) gesture_dir = -gesture_dir;
        if (pick < 14) return DELTA_W'(int'($urandom_range(0, 2)) * gesture_dir);
        if (pick < 18) return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        if (pick < 26) return DELTA_W'($urandom());
        mag = $urandom_range(1, scale);
        return DELTA_W'(mag * gesture_dir);
    endfunction

    function automatic logic [FTIME_W-1:0] draw_frame_time(input bit idle_heavy);
        int pick;
        pick = $urandom_range(0, 99);
        if (idle_heavy) begin
            if (pick < 4) return FTIME_W'($urandom());
            return FTIME_W'(16'hFFFF - $urandom_range(0, 63));
        end
        if (pick < 5) return '0;
        if (pick < 10) return 16'hFFFF;
        if (pick < 25) return FTIME_W'($urandom());
        return FTIME_W'($urandom_range(15000, 18000));
    endfunction

    // random upper bits must be masked off by the block
    function automatic logic [CFG_DAT_W-1:0] pad_reg16(input int value);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        return {junk, value[THR_W-1:0]};
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance with valid held.
    task automatic offer_frame(input logic signed [DELTA_W-1:0] delta,
                               input logic [FTIME_W-1:0] ft,
                               input logic check_fixed,
                               input logic signed [ACC_W-1:0] typed_steps);
        int gap;
        logic signed [ACC_W-1:0] predicted;
        gap = in_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_knob_delta = delta;
        i_frame_time_us = ft;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_cursor_steps(delta, ft);
        expected_steps.push_back(check_fixed ? typed_steps : predicted);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        i_cfg_index = idx;
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_THR_FIRST:  model_cfg.thr_first = value[THR_W-1:0];
            CFG_THR_SECOND: model_cfg.thr_second = value[THR_W-1:0];
            CFG_THR_NORMAL: model_cfg.thr_normal = value[THR_W-1:0];
            CFG_THR_FAST:   model_cfg.thr_fast = value[THR_W-1:0];
            CFG_DETECT:     model_cfg.detect_level = value[THR_W-1:0];
            CFG_IDLE_LIMIT: model_cfg.idle_limit = value[IDLE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_settings(input int thr_f, input int thr_s, input int thr_n,
                                 input int thr_q, input int det, input int limit);
        write_reg(CFG_THR_FIRST, pad_reg16(thr_f));
        write_reg(CFG_THR_SECOND, pad_reg16(thr_s));
        write_reg(CFG_THR_NORMAL, pad_reg16(thr_n));
        write_reg(CFG_THR_FAST, pad_reg16(thr_q));
        write_reg(CFG_DETECT, pad_reg16(det));
        write_reg(CFG_IDLE_LIMIT, limit[IDLE_W-1:0]);
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_for_drain();
        i_in_valid = 1'b0;
        while (expected_steps.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_frames(input int n, input int scale, input bit idle_heavy,
                              input int hold_at);
        for (int k = 0; k < n; k++) begin
            if (k % 32 == 0) begin
                in_idle_on = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (k == hold_at) hold_cycles = HOLD_LEN;
            offer_frame(draw_delta(scale), draw_frame_time(idle_heavy), 1'b0, '0);
        end
    endtask

    // result receiver
    initial begin
        int gap;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_cycles != 0) begin
                i_out_ready = 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            gap = out_idle_on ? $urandom_range(0, 9) : 0;
            if (gap != 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_steps.size() == 0) begin
                report_mismatch($sformatf("unexpected result, cursor_steps %0d", o_cursor_steps));
            end else begin
                oldest_steps = expected_steps.pop_front();
                if (o_cursor_steps !== oldest_steps)
                    report_mismatch($sformatf("cursor_steps %0d, predicted %0d",
                                              o_cursor_steps, oldest_steps));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        model_cfg.thr_first = 16'd512;
        model_cfg.thr_second = 16'd717;
        model_cfg.thr_normal = 16'd410;
        model_cfg.thr_fast = 16'd205;
        model_cfg.detect_level = 16'd1;
        model_cfg.idle_limit = 24'd300000;
        model_acc = '0;
        model_count = '0;
        model_idle = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            offer_frame(directed_rows[r].delta, directed_rows[r].ft,
                        directed_rows[r].check_fixed, directed_rows[r].typed_steps);

        // default settings, with a long output stall partway through
        run_frames(40, 3000, 1'b0, 20);
        wait_for_drain();

        // smallest thresholds, every nonzero delta active, zero idle limit
        load_settings(1, 1, 1, 1, 0, 0);
        write_reg(CFG_SPARE_6, CFG_DAT_W'($urandom()));
        write_reg(CFG_SPARE_7, CFG_DAT_W'($urandom()));
        run_frames(20, 200, 1'b0, -1);
        wait_for_drain();

        // largest values: nothing counts as activity, idle timer runs into saturation
        load_settings(65535, 65535, 65535, 65535, 65535, IDLE_MAX);
        run_frames(280, 32767, 1'b1, -1);
        wait_for_drain();

        // zero thresholds act as one
        load_settings(0, 3, 0, 7, 300, 50000);
        run_frames(20, 1000, 1'b0, -1);
        wait_for_drain();

        load_settings($urandom_range(64, 4000), $urandom_range(64, 4000),
                      $urandom_range(64, 4000), $urandom_range(64, 4000),
                      $urandom_range(0, 2000), $urandom_range(0, 400000));
        run_frames(25, $urandom_range(100, 20000), 1'b0, -1);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* knob_delta_to_cursor_steps_unit.f */
rtl/core/kdcs_pkg.sv
rtl/core/kdcs_ctrl.sv
rtl/core/kdcs_dp.sv
rtl/core/knob_delta_to_cursor_steps_unit.sv
tb/knob_delta_to_cursor_steps_unit_tb.sv
